/* rtl/tlpq_pkg.sv */
// Shared codes and types for the two-level process queue.
`timescale 1ns / 1ps

package tlpq_pkg;

    // Command codes carried by the action field
    localparam logic [2:0] ACT_INS_COMMON    = 3'd0;
    localparam logic [2:0] ACT_INS_PREFERRED = 3'd1;
    localparam logic [2:0] ACT_EXECUTE       = 3'd2;
    localparam logic [2:0] ACT_REMOVE        = 3'd3;
    localparam logic [2:0] ACT_MOVE_C2P      = 3'd4;
    localparam logic [2:0] ACT_MOVE_P2C      = 3'd5;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    // Output field widths
    localparam int OUT_ID_W  = 16;
    localparam int OUT_CNT_W = 5;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XFER,
        ST_TAKE,
        ST_SCAN,
        ST_COMPACT,
        ST_APPEND,
        ST_DONE
    } tlpq_state_t;

    // Per-cycle operation on one queue
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic push;
        logic pop;
        logic set_fill;
    } tlpq_qctl_t;

endpackage

/* rtl/tlpq_queue.sv */
// One circular id queue: storage memory, head pointer and fill count.
`timescale 1ns / 1ps

module tlpq_queue #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16,
    localparam int PTR_W  = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlpq_pkg::tlpq_qctl_t ctl,
    input  logic [PTR_W-1:0]     rd_off,
    input  logic [PTR_W-1:0]     wr_off,
    input  logic [ID_BITS-1:0]   wr_data,
    input  logic [CNT_W-1:0]     new_fill,
    output logic [ID_BITS-1:0]   rd_data,
    output logic [CNT_W-1:0]     fill
);

    localparam int SUM_W = PTR_W + 1;

    logic [ID_BITS-1:0] mem [DEPTH];
    logic [ID_BITS-1:0] rd_data_reg;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   head_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic [SUM_W-1:0]   rd_sum;
    logic [SUM_W-1:0]   wr_sum;
    logic [PTR_W-1:0]   rd_addr;
    logic [PTR_W-1:0]   wr_addr;

    // Map offsets from the head to physical addresses
    always_comb
    begin
        rd_sum = {1'b0, head_reg} + {1'b0, rd_off};
        wr_sum = {1'b0, head_reg} + {1'b0, wr_off};
        rd_addr = (rd_sum >= SUM_W'(DEPTH)) ? PTR_W'(rd_sum - SUM_W'(DEPTH)) : PTR_W'(rd_sum);
        wr_addr = (wr_sum >= SUM_W'(DEPTH)) ? PTR_W'(wr_sum - SUM_W'(DEPTH)) : PTR_W'(wr_sum);
    end

    // Advance head on pop, update fill count
    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (ctl.pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        priority if (ctl.set_fill)
        begin
            fill_next = new_fill;
        end
        else if (ctl.pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
        else if (ctl.push)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // Storage with registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign fill    = fill_reg;

endmodule

/* rtl/two_level_process_queue_core.sv */
// Top level of the two-level process queue: command controller and both queues.
`timescale 1ns / 1ps

// Usage:
// Commands enter on the cmd channel (cmd_valid / cmd_stall, fields action and
// proc_id); each command yields exactly one item on the rsp channel
// (rsp_valid / rsp_stall, fields status, taken_id, from_preferred,
// moved_count, common_count, preferred_count).
// One command is worked on at a time. Insert, unused commands and any command
// rejected at once go straight to the result; execute and remove first read
// the popped head, and execute appends it to the common tail.
// The move scans the source memory one entry per cycle, once to count matches
// and once to compact, then writes the matches to the target tail one per cycle.
// A new command is accepted the cycle after the previous result is loaded, so
// back-to-back inserts do not overlap.
// Each queue is a circular buffer in a memory with a registered read.
// The result sits in an output register; a stalled receiver holds it there and
// the controller then holds the next result, stalling cmd until it drains.
// Reset empties both queues (fill counts to zero, no memory clearing) and
// drops any pending result.

module two_level_process_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [2:0]  action,
    input  logic [15:0] proc_id,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [15:0] taken_id,
    output logic        from_preferred,
    output logic [4:0]  moved_count,
    output logic [4:0]  common_count,
    output logic [4:0]  preferred_count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tlpq_pkg::tlpq_state_t state_reg, state_next;
    logic [2:0]          act_reg, act_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [1:0]          stat_reg, stat_next;
    logic [ID_BITS-1:0]  taken_reg, taken_next;
    logic                pref_reg, pref_next;
    logic [CNT_W-1:0]    moved_reg, moved_next;
    logic [CNT_W-1:0]    match_reg, match_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    w_reg, w_next;
    logic                pend_reg, pend_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [1:0]          out_stat_reg;
    logic [15:0]         out_taken_reg;
    logic                out_pref_reg;
    logic [4:0]          out_moved_reg;
    logic [4:0]          out_ccnt_reg;
    logic [4:0]          out_pcnt_reg;
    logic                out_load;

    tlpq_pkg::tlpq_qctl_t c_ctl, p_ctl;
    logic [PTR_W-1:0]    c_rd_off, c_wr_off, p_rd_off, p_wr_off;
    logic [ID_BITS-1:0]  c_wr_data, p_wr_data, c_rd_data, p_rd_data;
    logic [CNT_W-1:0]    c_fill, p_fill, new_fill;

    logic [ID_BITS-1:0]  cmd_id;
    logic                mv_p2c;
    logic [CNT_W-1:0]    src_fill, dst_fill;
    logic [ID_BITS-1:0]  src_data;
    logic [CNT_W:0]      dst_sum;

    assign cmd_id   = ID_BITS'(proc_id);
    assign mv_p2c   = (act_reg == tlpq_pkg::ACT_MOVE_P2C);
    assign src_fill = mv_p2c ? p_fill : c_fill;
    assign dst_fill = mv_p2c ? c_fill : p_fill;
    assign src_data = mv_p2c ? p_rd_data : c_rd_data;
    assign dst_sum  = {1'b0, dst_fill} + {1'b0, match_reg};

    assign cmd_stall = (state_reg != tlpq_pkg::ST_IDLE);

    // Queues
    tlpq_queue #(
        .DEPTH   (QUEUE_DEPTH),
        .ID_BITS (ID_BITS)
    ) u_common (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (c_ctl),
        .rd_off   (c_rd_off),
        .wr_off   (c_wr_off),
        .wr_data  (c_wr_data),
        .new_fill (new_fill),
        .rd_data  (c_rd_data),
        .fill     (c_fill)
    );

    tlpq_queue #(
        .DEPTH   (QUEUE_DEPTH),
        .ID_BITS (ID_BITS)
    ) u_preferred (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (p_ctl),
        .rd_off   (p_rd_off),
        .wr_off   (p_wr_off),
        .wr_data  (p_wr_data),
        .new_fill (new_fill),
        .rd_data  (p_rd_data),
        .fill     (p_fill)
    );

    // Command sequencer
    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        id_next    = id_reg;
        stat_next  = stat_reg;
        taken_next = taken_reg;
        pref_next  = pref_reg;
        moved_next = moved_reg;
        match_next = match_reg;
        idx_next   = idx_reg;
        w_next     = w_reg;
        pend_next  = pend_reg;
        out_load   = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        c_ctl     = '0;
        p_ctl     = '0;
        c_rd_off  = PTR_W'(idx_reg);
        p_rd_off  = PTR_W'(idx_reg);
        c_wr_off  = PTR_W'(c_fill);
        p_wr_off  = PTR_W'(p_fill);
        c_wr_data = id_reg;
        p_wr_data = id_reg;
        new_fill  = w_reg;

        unique case (state_reg)
            tlpq_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    act_next   = action;
                    id_next    = cmd_id;
                    stat_next  = tlpq_pkg::STAT_OK;
                    taken_next = '0;
                    pref_next  = 1'b0;
                    moved_next = '0;
                    match_next = '0;
                    idx_next   = '0;
                    w_next     = '0;
                    pend_next  = 1'b0;
                    state_next = tlpq_pkg::ST_DONE;
                    c_wr_data  = cmd_id;
                    p_wr_data  = cmd_id;
                    c_rd_off   = '0;
                    p_rd_off   = '0;
                    unique case (action)
                        tlpq_pkg::ACT_INS_COMMON:
                        begin
                            if (c_fill < CNT_W'(QUEUE_DEPTH))
                            begin
                                c_ctl.wr_en = 1'b1;
                                c_ctl.push  = 1'b1;
                            end
                            else
                            begin
                                stat_next = tlpq_pkg::STAT_FULL;
                            end
                        end
                        tlpq_pkg::ACT_INS_PREFERRED:
                        begin
                            if (p_fill < CNT_W'(QUEUE_DEPTH))
                            begin
                                p_ctl.wr_en = 1'b1;
                                p_ctl.push  = 1'b1;
                            end
                            else
                            begin
                                stat_next = tlpq_pkg::STAT_FULL;
                            end
                        end
                        tlpq_pkg::ACT_EXECUTE,
                        tlpq_pkg::ACT_REMOVE:
                        begin
                            // Pop the head now unless the command is rejected; the data arrives next cycle
                            priority if (p_fill != '0)
                            begin
                                if (action == tlpq_pkg::ACT_EXECUTE &&
                                    c_fill >= CNT_W'(QUEUE_DEPTH))
                                begin
                                    stat_next = tlpq_pkg::STAT_FULL;
                                end
                                else
                                begin
                                    p_ctl.rd_en = 1'b1;
                                    p_ctl.pop   = 1'b1;
                                    pref_next   = 1'b1;
                                    state_next  = (action == tlpq_pkg::ACT_EXECUTE) ?
                                                  tlpq_pkg::ST_XFER : tlpq_pkg::ST_TAKE;
                                end
                            end
                            else if (c_fill != '0)
                            begin
                                c_ctl.rd_en = 1'b1;
                                c_ctl.pop   = 1'b1;
                                state_next  = (action == tlpq_pkg::ACT_EXECUTE) ?
                                              tlpq_pkg::ST_XFER : tlpq_pkg::ST_TAKE;
                            end
                            else
                            begin
                                stat_next = tlpq_pkg::STAT_EMPTY;
                            end
                        end
                        tlpq_pkg::ACT_MOVE_C2P:
                        begin
                            if (c_fill == '0)
                                stat_next = tlpq_pkg::STAT_EMPTY;
                            else
                                state_next = tlpq_pkg::ST_SCAN;
                        end
                        tlpq_pkg::ACT_MOVE_P2C:
                        begin
                            if (p_fill == '0)
                                stat_next = tlpq_pkg::STAT_EMPTY;
                            else
                                state_next = tlpq_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            stat_next = tlpq_pkg::STAT_OK;
                        end
                    endcase
                end
            end

            tlpq_pkg::ST_XFER:
            begin
                // Append the taken head to the common tail
                taken_next  = pref_reg ? p_rd_data : c_rd_data;
                c_wr_data   = pref_reg ? p_rd_data : c_rd_data;
                c_ctl.wr_en = 1'b1;
                c_ctl.push  = 1'b1;
                state_next  = tlpq_pkg::ST_DONE;
            end

            tlpq_pkg::ST_TAKE:
            begin
                taken_next = pref_reg ? p_rd_data : c_rd_data;
                state_next = tlpq_pkg::ST_DONE;
            end

            tlpq_pkg::ST_SCAN:
            begin
                // Count matches: issue one read per cycle, compare the returned data in the next cycle
                if (pend_reg && src_data == id_reg)
                begin
                    match_next = match_reg + 1'b1;
                end
                if (idx_reg < src_fill)
                begin
                    if (mv_p2c)
                        p_ctl.rd_en = 1'b1;
                    else
                        c_ctl.rd_en = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        idx_next = '0;
                        w_next   = '0;
                        priority if (match_reg == '0)
                        begin
                            stat_next  = tlpq_pkg::STAT_NOTFOUND;
                            state_next = tlpq_pkg::ST_DONE;
                        end
                        else if (dst_sum > (CNT_W + 1)'(QUEUE_DEPTH))
                        begin
                            stat_next  = tlpq_pkg::STAT_FULL;
                            state_next = tlpq_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = tlpq_pkg::ST_COMPACT;
                        end
                    end
                end
            end

            tlpq_pkg::ST_COMPACT:
            begin
                // Write back survivors toward the head; writes never pass reads
                c_wr_off  = PTR_W'(w_reg);
                p_wr_off  = PTR_W'(w_reg);
                c_wr_data = src_data;
                p_wr_data = src_data;
                if (pend_reg && src_data != id_reg)
                begin
                    if (mv_p2c)
                        p_ctl.wr_en = 1'b1;
                    else
                        c_ctl.wr_en = 1'b1;
                    w_next = w_reg + 1'b1;
                end
                if (idx_reg < src_fill)
                begin
                    if (mv_p2c)
                        p_ctl.rd_en = 1'b1;
                    else
                        c_ctl.rd_en = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (mv_p2c)
                            p_ctl.set_fill = 1'b1;
                        else
                            c_ctl.set_fill = 1'b1;
                        idx_next   = '0;
                        state_next = tlpq_pkg::ST_APPEND;
                    end
                end
            end

            tlpq_pkg::ST_APPEND:
            begin
                // Push the matched id to the target tail, one per cycle
                if (idx_reg != match_reg)
                begin
                    if (mv_p2c)
                    begin
                        c_ctl.wr_en = 1'b1;
                        c_ctl.push  = 1'b1;
                    end
                    else
                    begin
                        p_ctl.wr_en = 1'b1;
                        p_ctl.push  = 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    moved_next = match_reg;
                    state_next = tlpq_pkg::ST_DONE;
                end
            end

            tlpq_pkg::ST_DONE:
            begin
                // Hand the result over once the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    out_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = tlpq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tlpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlpq_pkg::ST_IDLE;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold command context and counters
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        id_reg    <= id_next;
        stat_reg  <= stat_next;
        taken_reg <= taken_next;
        pref_reg  <= pref_next;
        moved_reg <= moved_next;
        match_reg <= match_next;
        idx_reg   <= idx_next;
        w_reg     <= w_next;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_stat_reg  <= stat_reg;
            out_taken_reg <= tlpq_pkg::OUT_ID_W'(taken_reg);
            out_pref_reg  <= pref_reg && (stat_reg == tlpq_pkg::STAT_OK);
            out_moved_reg <= tlpq_pkg::OUT_CNT_W'(moved_reg);
            out_ccnt_reg  <= tlpq_pkg::OUT_CNT_W'(c_fill);
            out_pcnt_reg  <= tlpq_pkg::OUT_CNT_W'(p_fill);
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign status          = out_stat_reg;
    assign taken_id        = out_taken_reg;
    assign from_preferred  = out_pref_reg;
    assign moved_count     = out_moved_reg;
    assign common_count    = out_ccnt_reg;
    assign preferred_count = out_pcnt_reg;

    // Fill counts never pass the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_fill <= CNT_W'(QUEUE_DEPTH)) && (p_fill <= CNT_W'(QUEUE_DEPTH)))
        else $error("queue fill count beyond depth");

    // Compaction writes stay behind the reads
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlpq_pkg::ST_COMPACT) |-> (w_reg <= idx_reg))
        else $error("compaction write passed read pointer");

    // Appends only go into a queue with room
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlpq_pkg::ST_APPEND && idx_reg != match_reg) |->
        (dst_fill < CNT_W'(QUEUE_DEPTH)))
        else $error("append into full queue");

    // A result is raised only when leaving the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == tlpq_pkg::ST_DONE))
        else $error("result raised outside done state");

    // An accepted item always leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> (state_reg != tlpq_pkg::ST_IDLE))
        else $error("accepted item not started");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the two-level process queue core.
`timescale 1ns / 1ps

module tb_top;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam logic [15:0] ID_MASK = 16'((64'd1 << ID_BITS) - 1);
    localparam int HOLD_CYCLES = 200;
    localparam int TAIL_CYCLES = 3 * QUEUE_DEPTH + 8;

    // Action codes the block ignores
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] taken_id;
        logic        from_preferred;
        logic [4:0]  moved_count;
        logic [4:0]  common_count;
        logic [4:0]  preferred_count;
    } queue_result_t;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MOVE} traffic_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic [2:0]  action = tlpq_pkg::ACT_INS_COMMON;
    logic [15:0] proc_id = 16'd0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] taken_id;
    logic        from_preferred;
    logic [4:0]  moved_count;
    logic [4:0]  common_count;
    logic [4:0]  preferred_count;

    // Predicted contents of both queues, head first
    logic [15:0] common_ids[$];
    logic [15:0] preferred_ids[$];

    queue_result_t pending_results[$];
    queue_result_t seen_result;
    queue_result_t wanted_result;
    logic [15:0]   id_pool[4];
    int            mismatch_count = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_requests = 0;
    int            hold_served = 0;
    int            hold_left = 0;

    two_level_process_queue_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .action         (action),
        .proc_id        (proc_id),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .taken_id       (taken_id),
        .from_preferred (from_preferred),
        .moved_count    (moved_count),
        .common_count   (common_count),
        .preferred_count(preferred_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one command to the predicted queues and return the result it gives
    function automatic void predict_command(input logic [2:0] act, input logic [15:0] raw_id,
                                            output queue_result_t res);
        logic [15:0] id;
        logic [15:0] head;
        logic [15:0] src[$];
        logic [15:0] dst[$];
        int          match_total;
        int          k;
        id = raw_id & ID_MASK;
        res = '0;
        case (act)
            tlpq_pkg::ACT_INS_COMMON:
                if (common_ids.size() >= QUEUE_DEPTH)
                    res.status = tlpq_pkg::STAT_FULL;
                else
                    common_ids.push_back(id);
            tlpq_pkg::ACT_INS_PREFERRED:
                if (preferred_ids.size() >= QUEUE_DEPTH)
                    res.status = tlpq_pkg::STAT_FULL;
                else
                    preferred_ids.push_back(id);
            tlpq_pkg::ACT_EXECUTE:
            begin
                if (preferred_ids.size() != 0)
                begin
                    // preferred head can only rotate if common has room
                    if (common_ids.size() >= QUEUE_DEPTH)
                        res.status = tlpq_pkg::STAT_FULL;
                    else
                    begin
                        head = preferred_ids.pop_front();
                        res.taken_id = head;
                        res.from_preferred = 1'b1;
                        common_ids.push_back(head);
                    end
                end
                else if (common_ids.size() != 0)
                begin
                    head = common_ids.pop_front();
                    res.taken_id = head;
                    common_ids.push_back(head);
                end
                else
                    res.status = tlpq_pkg::STAT_EMPTY;
            end
            tlpq_pkg::ACT_REMOVE:
            begin
                if (preferred_ids.size() != 0)
                begin
                    res.taken_id = preferred_ids.pop_front();
                    res.from_preferred = 1'b1;
                end
                else if (common_ids.size() != 0)
                    res.taken_id = common_ids.pop_front();
                else
                    res.status = tlpq_pkg::STAT_EMPTY;
            end
            tlpq_pkg::ACT_MOVE_C2P, tlpq_pkg::ACT_MOVE_P2C:
            begin
                if (act == tlpq_pkg::ACT_MOVE_C2P)
                begin
                    src = common_ids;
                    dst = preferred_ids;
                end
                else
                begin
                    src = preferred_ids;
                    dst = common_ids;
                end
                match_total = 0;
                foreach (src[i])
                    if (src[i] == id)
                        match_total++;
                if (src.size() == 0)
                    res.status = tlpq_pkg::STAT_EMPTY;
                else if (match_total == 0)
                    res.status = tlpq_pkg::STAT_NOTFOUND;
                else if (dst.size() + match_total > QUEUE_DEPTH)
                    res.status = tlpq_pkg::STAT_FULL;
                else
                begin
                    // compact the source in order, then append all matching ids
                    k = 0;
                    while (k < src.size())
                        if (src[k] == id)
                            src.delete(k);
                        else
                            k++;
                    repeat (match_total) dst.push_back(id);
                    res.moved_count = 5'(match_total);
                    if (act == tlpq_pkg::ACT_MOVE_C2P)
                    begin
                        common_ids = src;
                        preferred_ids = dst;
                    end
                    else
                    begin
                        preferred_ids = src;
                        common_ids = dst;
                    end
                end
            end
            default: ;
        endcase
        res.common_count = 5'(common_ids.size());
        res.preferred_count = 5'(preferred_ids.size());
    endfunction

    // Offer one item after a random gap, wait for it to be taken, record its result
    task automatic issue_command(input logic [2:0] act, input logic [15:0] id);
        queue_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        action <= act;
        proc_id <= id;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predict_command(act, id, res);
        pending_results.push_back(res);
    endtask

    task automatic wait_for_drain();
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_id();
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return id_pool[$urandom_range(3)];
    endfunction

    function automatic void refresh_id_pool();
        foreach (id_pool[i])
            case ($urandom_range(5))
                0: id_pool[i] = 16'h0000;
                1: id_pool[i] = 16'hFFFF;
                default: id_pool[i] = 16'($urandom);
            endcase
    endfunction

    function automatic logic [2:0] pick_action(input traffic_mode_t mode);
        int roll;
        int lim[6];
        roll = $urandom_range(99);
        case (mode)
            MODE_FILL:  lim = '{35, 70, 80, 85, 92, 98};
            MODE_DRAIN: lim = '{10, 20, 55, 85, 90, 95};
            default:    lim = '{20, 35, 45, 50, 72, 97};
        endcase
        if (roll < lim[0])
            return tlpq_pkg::ACT_INS_COMMON;
        else if (roll < lim[1])
            return tlpq_pkg::ACT_INS_PREFERRED;
        else if (roll < lim[2])
            return tlpq_pkg::ACT_EXECUTE;
        else if (roll < lim[3])
            return tlpq_pkg::ACT_REMOVE;
        else if (roll < lim[4])
            return tlpq_pkg::ACT_MOVE_C2P;
        else if (roll < lim[5])
            return tlpq_pkg::ACT_MOVE_P2C;
        return ($urandom_range(1) == 0) ? ACT_SPARE_6 : ACT_SPARE_7;
    endfunction

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Execute, remove and both moves on empty queues, and one ignored action code
    task automatic test_empty_queues();
        issue_command(tlpq_pkg::ACT_EXECUTE, 16'h0000);
        issue_command(tlpq_pkg::ACT_REMOVE, 16'hFFFF);
        issue_command(tlpq_pkg::ACT_MOVE_C2P, 16'hFFFF);
        issue_command(tlpq_pkg::ACT_MOVE_P2C, 16'h0000);
        issue_command(ACT_SPARE_6, 16'hFFFF);
    endtask

    // Fill common to the brim and hit full, not-found and move cases
    task automatic test_full_queues();
        logic [15:0] id;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (i == 0)
                id = 16'h0000;
            else if (i == QUEUE_DEPTH - 1)
                id = 16'hFFFF;
            else if (i % 4 == 1)
                id = 16'h1234;
            else
                id = 16'h5A00 + 16'(i);
            issue_command(tlpq_pkg::ACT_INS_COMMON, id);
        end
        issue_command(tlpq_pkg::ACT_INS_COMMON, 16'h7777);
        issue_command(tlpq_pkg::ACT_INS_PREFERRED, 16'h1234);
        issue_command(tlpq_pkg::ACT_EXECUTE, 16'h0000);
        issue_command(tlpq_pkg::ACT_MOVE_P2C, 16'h1234);
        issue_command(tlpq_pkg::ACT_MOVE_C2P, 16'hBEEF);
        issue_command(ACT_SPARE_7, 16'h0000);
        issue_command(tlpq_pkg::ACT_MOVE_C2P, 16'h1234);
        issue_command(tlpq_pkg::ACT_EXECUTE, 16'hFFFF);
        issue_command(tlpq_pkg::ACT_REMOVE, 16'h0000);
    endtask

    // Phases that fill, drain or shuffle the queues with ids mostly from a small pool
    task automatic test_random_traffic(input int num_items);
        traffic_mode_t mode;
        int            phase_left;
        int            sent;
        phase_left = 0;
        mode = MODE_FILL;
        sent = 0;
        while (sent < num_items)
        begin
            if (phase_left == 0)
            begin
                mode = traffic_mode_t'($urandom_range(2));
                phase_left = $urandom_range(10, 40);
                refresh_id_pool();
            end
            issue_command(pick_action(mode), pick_id());
            phase_left--;
            sent++;
        end
    endtask

    // Hold results back for a long stretch while commands keep coming
    task automatic test_receiver_holdoff();
        hold_requests++;
        refresh_id_pool();
        repeat (12) issue_command(pick_action(MODE_MOVE), pick_id());
    endtask

    // Let the block go idle mid-stream, then empty both queues
    task automatic test_sender_pause();
        refresh_id_pool();
        repeat (8) issue_command(pick_action(MODE_FILL), pick_id());
        wait_for_drain();
        repeat (2 * QUEUE_DEPTH + 2) issue_command(tlpq_pkg::ACT_REMOVE, pick_id());
    endtask

    // Drive the receiver stall: long holds on request, random idling otherwise
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != hold_served)
        begin
            rsp_stall <= 1'b1;
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    assign seen_result = {status, taken_id, from_preferred, moved_count,
                          common_count, preferred_count};

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result at %0t: status %0d id %h pref %0d",
                             $realtime, status, taken_id, from_preferred,
                             " moved %0d cc %0d pc %0d",
                             moved_count, common_count, preferred_count);
            end
            else
            begin
                wanted_result = pending_results.pop_front();
                if (seen_result.status !== wanted_result.status
                    || seen_result.taken_id !== wanted_result.taken_id
                    || seen_result.from_preferred !== wanted_result.from_preferred
                    || seen_result.moved_count !== wanted_result.moved_count
                    || seen_result.common_count !== wanted_result.common_count
                    || seen_result.preferred_count !== wanted_result.preferred_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch at %0t: expected status %0d id %h pref %0d",
                                 $realtime, wanted_result.status, wanted_result.taken_id,
                                 wanted_result.from_preferred,
                                 " moved %0d cc %0d pc %0d,",
                                 wanted_result.moved_count,
                                 wanted_result.common_count, wanted_result.preferred_count,
                                 " got status %0d id %h pref %0d",
                                 seen_result.status, seen_result.taken_id,
                                 seen_result.from_preferred,
                                 " moved %0d cc %0d pc %0d",
                                 seen_result.moved_count,
                                 seen_result.common_count, seen_result.preferred_count);
                end
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(18, 55);
        test_empty_queues();
        test_full_queues();
        test_random_traffic(300);
        test_receiver_holdoff();

        set_idling(55, 18);
        test_random_traffic(300);
        test_sender_pause();

        set_idling(0, 0);
        test_random_traffic(300);
        test_receiver_holdoff();

        // Wait out every result, then watch for strays
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("two_level_process_queue_core regression: pass");
        else
            $display("two_level_process_queue_core regression: fail");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #10_000_000;
        $display("two_level_process_queue_core regression: fail");
        $finish;
    end

endmodule
